@@ rtl/core/assert_macros.svh @@
// Concurrent assertion helpers, clocked on i_clk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

`define ASSERT_IMPL(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

@@ rtl/core/mmet_pkg.sv @@
`timescale 1ns / 1ps

package mmet_pkg;

    localparam int TIME_WIDTH_DEF = 32;
    localparam int DELTA_W        = 24;
    localparam int PERIOD_W       = 31;
    localparam int MODE_W         = 3;
    localparam int OUT_W          = 32;
    localparam int FRAC_BITS      = 16;
    localparam int FRAC_W         = 17;
    localparam int IN_TDATA_W     = 32;
    localparam int OUT_FIELDS_W   = 116;
    localparam int OUT_TDATA_W    = 120;
    localparam int APB_AW         = 4;
    localparam int APB_DW         = 32;

    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

    localparam logic [MODE_W-1:0] MODE_ONESHOT  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_DELAYED  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RECUR    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_INTERVAL = 3'd3;
    localparam logic [MODE_W-1:0] MODE_COND     = 3'd4;

    localparam logic [1:0] REG_MODE   = 2'd0;
    localparam logic [1:0] REG_PERIOD = 2'd1;
    localparam logic [1:0] REG_DELAY  = 2'd2;
    localparam logic [1:0] REG_START  = 2'd3;

    typedef enum logic [1:0] {
        RUN_INACTIVE,
        RUN_PENDING,
        RUN_PAUSED,
        RUN_COMPLETED
    } t_run;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_FIRE,
        S_PREP,
        S_DIV,
        S_DONE
    } t_state;

endpackage

@@ rtl/core/multi_mode_event_timer_top.sv @@
// An accepted tick runs W serial add/subtract steps, W = max(TIME_WIDTH, 24) + 1, then fire,
// setup, 16 divide steps and the output load, which waits while the result register is full.
// A tick whose progress needs no division skips the divide steps; one on a timer that is not
// pending skips the add and fire steps.
// Ticks are taken only in idle; once a result is loaded, the result register lets the next tick in.
// Reset (synchronous, active low) loads the register defaults, leaving the timer inactive.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module multi_mode_event_timer_top #(
    parameter int TIME_WIDTH = mmet_pkg::TIME_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // delta_time[23:0], condition_met[24], zero fill
    input  logic [mmet_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // fired[0], run_state[2:1], time_left[34:3], time_spent[66:35],
    // fire_total[98:67], progress_frac[115:99], zero fill
    output logic [mmet_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mmet_pkg::APB_AW-1:0]      paddr,
    input  logic [mmet_pkg::APB_DW-1:0]      pwdata,
    output logic [mmet_pkg::APB_DW-1:0]      prdata,
    output logic                             pready
);
    import mmet_pkg::*;

    localparam int TW   = TIME_WIDTH;
    localparam int W    = ((TW > DELTA_W) ? TW : DELTA_W) + 1;
    localparam int CW   = (TW > OUT_W) ? TW : OUT_W;
    localparam int CNTW = $clog2(W);
    localparam logic [TW-1:0] SMAX = {1'b0, {(TW-1){1'b1}}};
    localparam logic [TW-1:0] SMIN = {1'b1, {(TW-1){1'b0}}};
    localparam logic [TW-1:0] UMAX = '1;

    function automatic logic [TW-1:0] clamp_load(input logic [PERIOD_W-1:0] v);
        logic [CW-1:0] ve;
        ve = CW'(v);
        if (ve > CW'(SMAX)) begin
            clamp_load = SMAX;
        end else begin
            clamp_load = ve[TW-1:0];
        end
    endfunction

    t_state                r_state, n_state;
    logic [MODE_W-1:0]     r_mode;
    logic [PERIOD_W-1:0]   r_period;
    logic [PERIOD_W-1:0]   r_delay;
    logic                  r_start;
    t_run                  r_run;
    logic signed [TW-1:0]  r_rem;
    logic [TW-1:0]         r_elap;
    logic [OUT_W-1:0]      r_fcnt;
    logic [W-1:0]          r_sa, r_sb, r_sd;
    logic                  r_ca, r_cb;
    logic [CNTW-1:0]       r_cnt;
    logic                  r_cond;
    logic                  r_fire;
    logic [PERIOD_W:0]     r_dr;
    logic [FRAC_BITS-1:0]  r_q;
    logic [FRAC_W-1:0]     r_prog;
    logic                  r_ov;
    logic [OUT_TDATA_W-1:0] r_od;

    logic                  cfg_wr;
    logic [1:0]            cfg_idx;
    logic [MODE_W-1:0]     n_mode;
    logic [PERIOD_W-1:0]   n_period, n_delay;
    logic                  n_start, n_valid;
    logic [TW-1:0]         n_load;
    logic                  in_acc, out_load;

    logic                  sum_a, sum_b, car_a, car_b;
    logic [W-TW:0]         rem_top;
    logic                  elap_ovf, rem_ovf, fire_now, reload;
    logic [TW-1:0]         sat_elap, sat_rem;

    logic                  rem_le0, rem_ge_dur, prep_special;
    logic [FRAC_W-1:0]     prep_val;
    logic [PERIOD_W-1:0]   done_time;
    logic [PERIOD_W:0]     div_t, div_d;
    logic                  div_ge;
    logic [FRAC_BITS-1:0]  q_next;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_comb begin
        n_mode   = (cfg_wr && cfg_idx == REG_MODE)   ? pwdata[MODE_W-1:0]   : r_mode;
        n_period = (cfg_wr && cfg_idx == REG_PERIOD) ? pwdata[PERIOD_W-1:0] : r_period;
        n_delay  = (cfg_wr && cfg_idx == REG_DELAY)  ? pwdata[PERIOD_W-1:0] : r_delay;
        n_start  = (cfg_wr && cfg_idx == REG_START)  ? pwdata[0]            : r_start;
        n_valid  = (n_mode <= MODE_COND) && ((n_period != '0) || (n_mode == MODE_COND));
        n_load   = clamp_load((n_delay != '0) ? n_delay : n_period);
    end

    always_comb begin
        case (cfg_idx)
            REG_MODE:   prdata = APB_DW'(r_mode);
            REG_PERIOD: prdata = APB_DW'(r_period);
            REG_DELAY:  prdata = APB_DW'(r_delay);
            REG_START:  prdata = APB_DW'(r_start);
            default:    prdata = '0;
        endcase
    end

    // serial add and subtract, one bit a cycle
    always_comb begin
        sum_a = r_sa[0] ^ r_sd[0] ^ r_ca;
        car_a = (r_sa[0] & r_sd[0]) | (r_ca & (r_sa[0] ^ r_sd[0]));
        sum_b = r_sb[0] ^ ~r_sd[0] ^ r_cb;
        car_b = (r_sb[0] & ~r_sd[0]) | (r_cb & (r_sb[0] ^ ~r_sd[0]));
    end

    // saturate and decide the fire
    always_comb begin
        elap_ovf = |r_sa[W-1:TW];
        sat_elap = elap_ovf ? UMAX : r_sa[TW-1:0];
        rem_top  = r_sb[W-1:TW-1];
        rem_ovf  = !((&rem_top) || !(|rem_top));
        sat_rem  = rem_ovf ? SMIN : r_sb[TW-1:0];
        fire_now = (r_mode == MODE_COND) ? r_cond : (sat_rem[TW-1] || (sat_rem == '0));
        reload   = (r_mode == MODE_RECUR) || (r_mode == MODE_INTERVAL);
    end

    // progress: special cases and divider setup
    always_comb begin
        rem_le0    = r_rem[TW-1] || (r_rem == '0);
        rem_ge_dur = CW'($unsigned(r_rem)) >= CW'(r_period);
        done_time  = r_period - PERIOD_W'(r_rem);
        prep_special = 1'b1;
        prep_val     = '0;
        if (r_mode == MODE_COND) begin
            prep_val = '0;
        end else if ((r_period == '0) || rem_le0) begin
            prep_val = FRAC_ONE;
        end else if (rem_ge_dur) begin
            prep_val = '0;
        end else begin
            prep_special = 1'b0;
        end
        div_d  = {1'b0, r_period};
        div_t  = {r_dr[PERIOD_W-1:0], 1'b0};
        div_ge = div_t >= div_d;
        q_next = {r_q[FRAC_BITS-2:0], div_ge};
    end

    // sequencer
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = (r_run == RUN_PENDING) ? S_ADD : S_PREP;
                end
            end
            S_ADD: begin
                if (r_cnt == CNTW'(W - 1)) begin
                    n_state = S_FIRE;
                end
            end
            S_FIRE: n_state = S_PREP;
            S_PREP: n_state = prep_special ? S_DONE : S_DIV;
            S_DIV: begin
                if (r_cnt == CNTW'(FRAC_BITS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ov || i_m_axis_tready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // timer state and registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_ONESHOT;
            r_period <= '0;
            r_delay  <= '0;
            r_start  <= 1'b1;
            r_run    <= RUN_INACTIVE;
            r_rem    <= '0;
            r_elap   <= '0;
            r_fcnt   <= '0;
        end else if (cfg_wr) begin
            r_mode   <= n_mode;
            r_period <= n_period;
            r_delay  <= n_delay;
            r_start  <= n_start;
            r_run    <= n_valid ? (n_start ? RUN_PENDING : RUN_PAUSED) : RUN_INACTIVE;
            r_rem    <= n_valid ? n_load : '0;
            r_elap   <= '0;
            r_fcnt   <= '0;
        end else if (r_state == S_FIRE) begin
            r_elap <= sat_elap;
            r_rem  <= (fire_now && reload) ? clamp_load(r_period) : sat_rem;
            if (fire_now) begin
                if (r_fcnt != '1) begin
                    r_fcnt <= r_fcnt + 1'b1;
                end
                if ((r_mode == MODE_ONESHOT) || (r_mode == MODE_DELAYED)) begin
                    r_run <= RUN_COMPLETED;
                end
            end
        end
    end

    // serial datapath and divider
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_sa   <= W'(r_elap);
                    r_sb   <= W'(r_rem);
                    r_sd   <= W'(i_s_axis_tdata[DELTA_W-1:0]);
                    r_ca   <= 1'b0;
                    r_cb   <= 1'b1;
                    r_cnt  <= '0;
                    r_cond <= i_s_axis_tdata[DELTA_W];
                    r_fire <= 1'b0;
                end
            end
            S_ADD: begin
                r_sa  <= {sum_a, r_sa[W-1:1]};
                r_sb  <= {sum_b, r_sb[W-1:1]};
                r_sd  <= {1'b0, r_sd[W-1:1]};
                r_ca  <= car_a;
                r_cb  <= car_b;
                r_cnt <= r_cnt + 1'b1;
            end
            S_FIRE: r_fire <= fire_now;
            S_PREP: begin
                r_prog <= prep_val;
                r_dr   <= {1'b0, done_time};
                r_q    <= '0;
                r_cnt  <= '0;
            end
            S_DIV: begin
                r_dr   <= div_ge ? (div_t - div_d) : div_t;
                r_q    <= q_next;
                r_prog <= {1'b0, q_next};
                r_cnt  <= r_cnt + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_od <= {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, r_prog, r_fcnt,
                     OUT_W'(r_elap), OUT_W'(r_rem), r_run, r_fire};
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_od;

    `ASSERT_CLK(a_skip_add, (in_acc && r_run != RUN_PENDING) |=> (r_state == S_PREP), "idle add")
    `ASSERT_IMPL(a_fire_counted, r_ov && r_od[0], r_od[98:67] != '0, "fire with zero count")
    `ASSERT_IMPL(a_progress_range, r_ov, r_od[115:99] <= FRAC_ONE, "progress above one")
    `ASSERT_IMPL(a_div_remainder, r_state == S_DIV, r_dr < div_d, "remainder above duration")

endmodule
